// File: hdl/hil_pkg.sv
// Shared constants, request codes and structs for the indexed handle list.
package hil_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned ADDR_BITS  = $clog2(DEPTH);
  localparam int unsigned COUNT_BITS = $clog2(DEPTH + 1);
  localparam int unsigned POS_BITS   = 10;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned REQ_BITS   = 3;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_APPEND      = 3'd0,
    REQ_REMOVE_HEAD = 3'd1,
    REQ_READ_AT     = 3'd2,
    REQ_REMOVE_AT   = 3'd3,
    REQ_INSERT_AT   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic                   ok;
    logic [COUNT_BITS-1:0]  count;
  } result_t;

endpackage

// File: hdl/hil_store.sv
// Entry store of the handle list: one write port and one registered read port.
module hil_store
  import hil_pkg::*;
(
  input  logic                 clk_i,
  input  mem_req_t             mem_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
    rdata_q <= mem_q[mem_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/hil_seq.sv
// Sequencer that checks each request and moves entries one at a time.
module hil_seq
  import hil_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [REQ_BITS-1:0]    req_type_i,
  input  logic [POS_BITS-1:0]    position_i,
  input  logic [HANDLE_BITS-1:0] handle_in_i,
  input  logic [WORD_BITS-1:0]   rdata_i,
  input  logic                   res_take_i,
  output logic                   idle_o,
  output logic                   res_valid_o,
  output result_t                res_o,
  output mem_req_t               mem_o
);

  state_e                 state_q, state_d;
  req_e                   req_q, req_d;
  logic [ADDR_BITS-1:0]   pos_q, pos_d;
  logic [ADDR_BITS-1:0]   idx_q, idx_d;
  logic [COUNT_BITS-1:0]  fill_q, fill_d;
  logic [WORD_BITS-1:0]   word_q, word_d;
  logic [WORD_BITS-1:0]   hout_q, hout_d;
  logic                   ok_q, ok_d;
  logic [COUNT_BITS-1:0]  pos_ext;
  logic                   not_full;

  assign pos_ext  = COUNT_BITS'(position_i);
  assign not_full = fill_q < COUNT_BITS'(DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    word_q <= word_d;
    hout_q <= hout_d;
    ok_q   <= ok_d;
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    word_d  = word_q;
    hout_d  = hout_q;
    ok_d    = ok_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = idx_q;
    mem_o.wdata = rdata_i;
    mem_o.raddr = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_e'(req_type_i);
          pos_d   = ADDR_BITS'(position_i);
          idx_d   = ADDR_BITS'(position_i);
          word_d  = handle_in_i[WORD_BITS-1:0];
          hout_d  = '0;
          ok_d    = 1'b0;
          state_d = ST_DONE;
          case (req_type_i)
            REQ_APPEND: begin
              if (not_full) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = fill_q[ADDR_BITS-1:0];
                mem_o.wdata = handle_in_i[WORD_BITS-1:0];
                fill_d      = fill_q + 1'b1;
                ok_d        = 1'b1;
              end
            end
            REQ_REMOVE_HEAD: begin
              pos_d = '0;
              idx_d = '0;
              mem_o.raddr = '0;
              if (fill_q != '0) begin
                ok_d    = 1'b1;
                state_d = ST_GET;
              end
            end
            REQ_READ_AT, REQ_REMOVE_AT: begin
              mem_o.raddr = ADDR_BITS'(position_i);
              if (pos_ext < fill_q) begin
                ok_d    = 1'b1;
                state_d = ST_GET;
              end
            end
            REQ_INSERT_AT: begin
              if (not_full && pos_ext <= fill_q) begin
                ok_d    = 1'b1;
                idx_d   = fill_q[ADDR_BITS-1:0];
                state_d = (pos_ext == fill_q) ? ST_PUT : ST_SHIFT_RD;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_GET: begin
        hout_d = rdata_i;
        if (req_q == REQ_READ_AT) begin
          state_d = ST_DONE;
        end else if ((COUNT_BITS'(idx_q) + 1'b1) < fill_q) begin
          state_d = ST_SHIFT_RD;
        end else begin
          fill_d  = fill_q - 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_SHIFT_RD: begin
        if (req_q == REQ_INSERT_AT) begin
          mem_o.raddr = idx_q - 1'b1;
        end else begin
          mem_o.raddr = idx_q + 1'b1;
        end
        state_d = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        mem_o.we = 1'b1;
        if (req_q == REQ_INSERT_AT) begin
          idx_d   = idx_q - 1'b1;
          state_d = ((idx_q - 1'b1) > pos_q) ? ST_SHIFT_RD : ST_PUT;
        end else begin
          idx_d = idx_q + 1'b1;
          if ((COUNT_BITS'(idx_q) + COUNT_BITS'(2)) < fill_q) begin
            state_d = ST_SHIFT_RD;
          end else begin
            fill_d  = fill_q - 1'b1;
            state_d = ST_DONE;
          end
        end
      end

      ST_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        mem_o.wdata = word_q;
        fill_d      = fill_q + 1'b1;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign res_valid_o  = (state_q == ST_DONE);
  assign res_o.handle = HANDLE_BITS'(hout_q);
  assign res_o.ok     = ok_q;
  assign res_o.count  = fill_q;

endmodule

// File: hdl/indexed_handle_list_unit.sv
// Top level of the indexed handle list: sequencer, entry store and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   request | in        | in_valid_i / in_stall_o  | req_type_i, position_i, handle_in_i
//   result  | out       | out_valid_o / out_stall_i | handle_out_o, ok_o, count_now_o
//
// Append and failed requests go straight to the result; a read first reads the store.
// Remove and insert move one entry at a time, a read then a write, through the single store
// read port and write port: remove moves count - position - 1 entries, insert moves
// count - position entries and then writes the new handle.
// Reset empties the list at once; the store itself is not cleared.
// A finished result sits in the result register until taken; a result that
// finds that register still full waits in the sequencer.
module indexed_handle_list_unit
  import hil_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [REQ_BITS-1:0]    req_type_i,
  input  logic [POS_BITS-1:0]    position_i,
  input  logic [HANDLE_BITS-1:0] handle_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [HANDLE_BITS-1:0] handle_out_o,
  output logic                   ok_o,
  output logic [COUNT_BITS-1:0]  count_now_o
);

  logic                 seq_idle;
  logic                 res_valid;
  logic                 res_take;
  logic                 start;
  result_t              res;
  result_t              out_q;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rdata;
  logic                 out_valid_q, out_valid_d;

  // A request is taken only while the sequencer has nothing in flight.
  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;

  // The result register loads whenever it is empty or being emptied.
  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take || (out_valid_q && out_stall_i);

  hil_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .handle_in_i (handle_in_i),
    .rdata_i     (rdata),
    .res_take_i  (res_take),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_o       (mem_req)
  );

  hil_store u_store (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = out_q.handle;
  assign ok_o         = out_q.ok;
  assign count_now_o  = out_q.count;

endmodule

// File: hdl/hil_checker.sv
// Port-level assertions for the indexed handle list, bound to the top level.
module hil_checker
  import hil_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [HANDLE_BITS-1:0] handle_out_o,
  input logic                   ok_o,
  input logic [COUNT_BITS-1:0]  count_now_o
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(handle_out_o)
      && $stable(ok_o) && $stable(count_now_o))
    else $error("stalled result changed");

  // A failed request never returns a handle.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> handle_out_o == '0)
    else $error("failed request carries a handle");

  // The count never exceeds the list depth.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_now_o <= COUNT_BITS'(DEPTH))
    else $error("count above depth");

  // After a request is taken the block is busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken on back-to-back cycles");

endmodule

bind indexed_handle_list_unit hil_checker u_hil_checker (.*);

// File: tb/sv/tb_indexed_handle_list_unit.sv
// Self-checking testbench for the indexed handle list unit.
`timescale 1ns / 1ps

module tb_indexed_handle_list_unit;
  import hil_pkg::*;

  localparam int unsigned CLK_HALF = 5;
  // The slowest request moves every entry of a full list.
  localparam int unsigned SLOWEST_REQ = 2 * DEPTH + 8;
  localparam int unsigned DRAIN_CYCLES = SLOWEST_REQ + 100;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned RANDOM_PER_PHASE = 400;
  // Random traffic keeps the list short so that shifts stay cheap.
  localparam int unsigned FILL_SOFT_CAP = 40;
  localparam int unsigned FILL_HARD_CAP = 64;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED_LAST = '1;
  localparam logic [POS_BITS-1:0] POS_LAST = '1;
  localparam logic [POS_BITS-1:0] POS_MID = POS_BITS'(DEPTH / 2);
  localparam logic [HANDLE_BITS-1:0] HANDLE_ONES = '1;
  localparam logic [HANDLE_BITS-1:0] HANDLE_ALT_A = 32'hA5A5_A5A5;
  localparam logic [HANDLE_BITS-1:0] HANDLE_ALT_B = 32'h5A5A_5A5A;

  // The scoreboard keeps its own copy of the list as a queue of handles.
  // Every accepted request updates that copy and queues the result it must
  // produce; every accepted result is checked against the oldest one.
  class handle_list_scoreboard;
    logic [HANDLE_BITS-1:0] held[$];
    result_t                pending[$];
    int unsigned            fail_cnt;

    function int unsigned fill();
      return held.size();
    endfunction

    function void note_request(logic [REQ_BITS-1:0] req, logic [POS_BITS-1:0] pos,
                               logic [HANDLE_BITS-1:0] handle);
      result_t     exp_res;
      int unsigned idx;
      exp_res = '0;
      idx = pos;
      case (req)
        REQ_APPEND: begin
          if (held.size() < DEPTH) begin
            held.push_back(handle);
            exp_res.ok = 1'b1;
          end
        end
        REQ_REMOVE_HEAD: begin
          if (held.size() > 0) begin
            exp_res.handle = held.pop_front();
            exp_res.ok = 1'b1;
          end
        end
        REQ_READ_AT: begin
          if (idx < held.size()) begin
            exp_res.handle = held[idx];
            exp_res.ok = 1'b1;
          end
        end
        REQ_REMOVE_AT: begin
          if (idx < held.size()) begin
            exp_res.handle = held[idx];
            held.delete(idx);
            exp_res.ok = 1'b1;
          end
        end
        REQ_INSERT_AT: begin
          if (held.size() < DEPTH && idx <= held.size()) begin
            held.insert(idx, handle);
            exp_res.ok = 1'b1;
          end
        end
        default: begin
          // Unused request codes leave the list alone and report a failure.
        end
      endcase
      exp_res.count = COUNT_BITS'(held.size());
      pending.push_back(exp_res);
    endfunction

    function void check_result(logic [HANDLE_BITS-1:0] handle, logic ok,
                               logic [COUNT_BITS-1:0] count);
      result_t exp_res;
      if (pending.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("unexpected result: handle %h ok %b count %0d", handle, ok, count);
        return;
      end
      exp_res = pending.pop_front();
      if (exp_res.handle !== handle || exp_res.ok !== ok || exp_res.count !== count) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("result mismatch: expected handle %h ok %b count %0d, got handle %h ok %b count %0d",
                   exp_res.handle, exp_res.ok, exp_res.count, handle, ok, count);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [REQ_BITS-1:0]    req_type_i;
  logic [POS_BITS-1:0]    position_i;
  logic [HANDLE_BITS-1:0] handle_in_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [HANDLE_BITS-1:0] handle_out_o;
  logic                   ok_o;
  logic [COUNT_BITS-1:0]  count_now_o;

  // Idle rates in percent for the request side and the result side.
  int unsigned tx_idle_pct = 24;
  int unsigned rx_idle_pct = 45;

  // The main process asks once for a long hold-off on the result side; the
  // receiver process counts it down on its own.
  logic        start_hold = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  handle_list_scoreboard sb = new();

  indexed_handle_list_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .handle_in_i (handle_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .handle_out_o(handle_out_o),
    .ok_o        (ok_o),
    .count_now_o (count_now_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // The result side stalls at random, or without a break during the hold-off.
  // Its input changes only at the falling edge.
  always @(negedge clk_i) begin
    if (start_hold && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < rx_idle_pct);
    end
  end

  // Results are taken at the rising edge where valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(handle_out_o, ok_o, count_now_o);
  end

  // A hung block must not hold the run forever.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one request, starting just after a falling edge, and returns just
  // after the falling edge that follows its acceptance. Valid is touched once
  // per falling edge, and the payload holds while the block stalls.
  task automatic send_req(input logic [REQ_BITS-1:0] req, input logic [POS_BITS-1:0] pos,
                          input logic [HANDLE_BITS-1:0] handle);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    handle_in_i <= handle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req, pos, handle);
    @(negedge clk_i);
  endtask

  function automatic logic [POS_BITS-1:0] held_position(int unsigned fill);
    return (fill == 0) ? '0 : POS_BITS'($urandom_range(fill - 1, 0));
  endfunction

  // Mostly well-formed requests on a short list, with the list kept between
  // a few and a few dozen entries; the rest are unused codes and requests
  // with a position drawn from the whole field, which mostly fail.
  task automatic send_random();
    logic [REQ_BITS-1:0] req;
    logic [POS_BITS-1:0] pos;
    int unsigned         fill;
    int unsigned         pick;
    int unsigned         grow_pct;
    fill = sb.fill();
    pick = $urandom_range(99, 0);
    pos = POS_BITS'($urandom());
    if (pick < 6) begin
      req = REQ_BITS'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
    end else if (pick < 12) begin
      req = REQ_BITS'($urandom_range(REQ_INSERT_AT, REQ_APPEND));
    end else if (pick < 30) begin
      req = REQ_READ_AT;
      pos = held_position(fill);
    end else begin
      if (fill < 6)
        grow_pct = 75;
      else if (fill >= FILL_HARD_CAP)
        grow_pct = 0;
      else if (fill > FILL_SOFT_CAP)
        grow_pct = 25;
      else
        grow_pct = 50;
      if ($urandom_range(99, 0) < grow_pct) begin
        if ($urandom_range(1, 0) == 0) begin
          req = REQ_APPEND;
        end else begin
          req = REQ_INSERT_AT;
          pos = POS_BITS'($urandom_range(fill, 0));
        end
      end else begin
        if ($urandom_range(2, 0) == 0) begin
          req = REQ_REMOVE_HEAD;
        end else begin
          req = REQ_REMOVE_AT;
          pos = held_position(fill);
        end
      end
    end
    send_req(req, pos, $urandom());
  endtask

  initial begin
    in_valid_i = 1'b0;
    req_type_i = REQ_APPEND;
    position_i = '0;
    handle_in_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests on an empty and a short list. Every failing case is
    // hit: an empty list, positions past the end, and the unused codes.
    // Inserting at the end position behaves as an append.
    send_req(REQ_REMOVE_HEAD, '0, '0);
    send_req(REQ_READ_AT, '0, '0);
    send_req(REQ_REMOVE_AT, '0, '0);
    send_req(REQ_INSERT_AT, POS_BITS'(1), HANDLE_ALT_A);
    send_req(REQ_INSERT_AT, '0, HANDLE_ONES);
    send_req(REQ_APPEND, '0, '0);
    send_req(REQ_APPEND, POS_LAST, HANDLE_ALT_A);
    send_req(REQ_INSERT_AT, POS_BITS'(1), HANDLE_ALT_B);
    send_req(REQ_INSERT_AT, POS_BITS'(4), HANDLE_BITS'(1));
    send_req(REQ_INSERT_AT, POS_BITS'(6), HANDLE_ONES);
    send_req(REQ_READ_AT, POS_BITS'(4), '0);
    send_req(REQ_READ_AT, POS_BITS'(5), '0);
    send_req(REQ_READ_AT, POS_LAST, '0);
    send_req(REQ_REMOVE_AT, POS_BITS'(2), '0);
    send_req(REQ_REMOVE_AT, POS_BITS'(3), '0);
    send_req(REQ_REMOVE_AT, POS_BITS'(4), '0);
    send_req(REQ_REMOVE_HEAD, '0, '0);
    send_req(REQ_UNUSED_FIRST, POS_LAST, HANDLE_ONES);
    send_req(REQ_UNUSED_FIRST + 3'd1, POS_LAST, HANDLE_ONES);
    send_req(REQ_UNUSED_LAST, POS_LAST, HANDLE_ONES);
    send_req(REQ_READ_AT, '0, '0);
    send_req(REQ_REMOVE_AT, '0, '0);
    send_req(REQ_REMOVE_HEAD, '0, '0);

    repeat (RANDOM_PER_PHASE) send_random();
    tx_idle_pct = 45;
    rx_idle_pct = 24;
    repeat (RANDOM_PER_PHASE) send_random();
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // Fill the list to the brim while the result side holds off for a long
    // stretch, so that the block backs up and stalls its request side.
    start_hold <= 1'b1;
    while (sb.fill() < DEPTH) send_req(REQ_APPEND, POS_BITS'($urandom()), $urandom());

    // A full list: growth fails, the last entry is reachable, and removing
    // or inserting at the head shifts every entry.
    send_req(REQ_APPEND, '0, HANDLE_ONES);
    send_req(REQ_INSERT_AT, '0, HANDLE_ONES);
    send_req(REQ_INSERT_AT, POS_LAST, HANDLE_ONES);
    send_req(REQ_READ_AT, POS_LAST, '0);
    send_req(REQ_READ_AT, '0, '0);
    send_req(REQ_REMOVE_AT, POS_LAST, '0);
    send_req(REQ_REMOVE_AT, POS_LAST, '0);
    send_req(REQ_READ_AT, POS_LAST, '0);
    send_req(REQ_INSERT_AT, POS_LAST, $urandom());
    send_req(REQ_REMOVE_AT, '0, '0);
    send_req(REQ_INSERT_AT, '0, $urandom());
    send_req(REQ_REMOVE_HEAD, '0, '0);
    send_req(REQ_INSERT_AT, POS_MID, $urandom());
    send_req(REQ_REMOVE_AT, POS_MID, '0);
    send_req(REQ_APPEND, POS_LAST, '0);
    repeat (12) send_req(REQ_READ_AT, POS_BITS'($urandom()), '0);
    in_valid_i <= 1'b0;

    // Wait for the outstanding results, then long enough for any stray one.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_cnt == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/hil_pkg.sv
hdl/hil_store.sv
hdl/hil_seq.sv
hdl/indexed_handle_list_unit.sv
hdl/hil_checker.sv
tb/sv/tb_indexed_handle_list_unit.sv
